// File: design/dap_pkg.sv
// Package for the decimal amount parser: field widths, byte codes, status codes,
// the parse phase type, the job record passed from front to back, and a power-of-ten table.
// No dependencies.
package dap_pkg;

    localparam int CH_W       = 8;
    localparam int STATUS_W   = 3;
    localparam int AMOUNT_W   = 60;
    localparam int VAL_W      = 30;    // holds up to nine decimal digits
    localparam int CNT_W      = 4;     // digit counters, up to nine

    localparam int DEF_WHOLE_DIGITS    = 9;
    localparam int DEF_FRACTION_DIGITS = 9;
    localparam int DEF_QUEUE_DEPTH     = 4;

    localparam logic [AMOUNT_W-1:0] RESET_MAX = 60'd999999999999999999;

    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_POINT = 8'h2E;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_BLANK = 3'd1,
        ST_BAD   = 3'd2,
        ST_LONG  = 3'd3,
        ST_ABOVE = 3'd4
    } status_t;

    typedef enum logic [4:0] {
        PH_LEAD  = 5'b00001,
        PH_WHOLE = 5'b00010,
        PH_FRAC  = 5'b00100,
        PH_TRAIL = 5'b01000,
        PH_BAD   = 5'b10000
    } phase_t;

    typedef struct packed {
        status_t            status;
        logic [VAL_W-1:0]   whole;
        logic [VAL_W-1:0]   frac;
        logic [CNT_W-1:0]   frac_place;
    } job_t;

    function automatic logic [VAL_W-1:0] pow10(input logic [CNT_W-1:0] n);
        logic [VAL_W-1:0] r;
        case (n)
            4'd0:    r = 30'd1;
            4'd1:    r = 30'd10;
            4'd2:    r = 30'd100;
            4'd3:    r = 30'd1000;
            4'd4:    r = 30'd10000;
            4'd5:    r = 30'd100000;
            4'd6:    r = 30'd1000000;
            4'd7:    r = 30'd10000000;
            4'd8:    r = 30'd100000000;
            4'd9:    r = 30'd1000000000;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

endpackage

// File: design/dap_text_if.sv
// Byte stream channel into the parser: valid/ready handshake with ch and last.
// Depends on dap_pkg.
interface dap_text_if;
    import dap_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] ch;
    logic            last;

    modport source (output valid, ch, last, input ready);
    modport sink   (input valid, ch, last, output ready);
endinterface

// File: design/dap_result_if.sv
// Result channel out of the parser: valid/ready handshake with status and amount.
// Depends on dap_pkg.
interface dap_result_if;
    import dap_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [AMOUNT_W-1:0] amount;

    modport source (output valid, status, amount, input ready);
    modport sink   (input valid, status, amount, output ready);
endinterface

// File: design/dap_front.sv
// Front end: takes one text byte per cycle unless q_full, tracks parse phase and digit
// values, and on the last byte pushes a classified job. Depends on dap_pkg, dap_text_if.
module dap_front #(
    parameter int WHOLE_DIGITS    = dap_pkg::DEF_WHOLE_DIGITS,
    parameter int FRACTION_DIGITS = dap_pkg::DEF_FRACTION_DIGITS
) (
    input  logic          clk,
    input  logic          rst_n,
    dap_text_if.sink      text,
    input  logic          q_full,
    output logic          q_push,
    output dap_pkg::job_t q_job
);
    import dap_pkg::*;

    phase_t           phase_reg, phase_next;
    logic [VAL_W-1:0] whole_reg, whole_next;
    logic [CNT_W-1:0] whole_cnt_reg, whole_cnt_next;
    logic             too_long_reg, too_long_next;
    logic [VAL_W-1:0] frac_reg, frac_next;
    logic [CNT_W-1:0] place_reg, place_next;

    logic             is_space, is_digit, is_point, take;
    logic [CNT_W-1:0] digit;
    phase_t           ph;

    assign text.ready = !q_full;
    assign take       = text.valid && text.ready;
    assign is_space   = (text.ch == CH_SPACE) || (text.ch >= CH_TAB && text.ch <= CH_CR);
    assign is_digit   = (text.ch >= CH_ZERO) && (text.ch <= CH_NINE);
    assign is_point   = (text.ch == CH_POINT);
    assign digit      = CNT_W'(text.ch - CH_ZERO);

    always_comb
    begin
        phase_next     = phase_reg;
        whole_next     = whole_reg;
        whole_cnt_next = whole_cnt_reg;
        too_long_next  = too_long_reg;
        frac_next      = frac_reg;
        place_next     = place_reg;
        q_push         = 1'b0;
        q_job          = '0;
        ph             = phase_reg;

        if (take)
        begin
            if (phase_reg == PH_BAD)
            begin
                phase_next = PH_BAD;
            end
            else if (is_space)
            begin
                if (phase_reg == PH_WHOLE || phase_reg == PH_FRAC)
                    phase_next = PH_TRAIL;
            end
            else if (is_point)
            begin
                if (phase_reg == PH_LEAD || phase_reg == PH_WHOLE)
                    phase_next = PH_FRAC;
                else
                    phase_next = PH_BAD;
            end
            else if (is_digit)
            begin
                ph = (phase_reg == PH_LEAD) ? PH_WHOLE : phase_reg;
                phase_next = ph;
                if (ph == PH_WHOLE)
                begin
                    if (whole_cnt_reg < CNT_W'(WHOLE_DIGITS))
                    begin
                        whole_next     = VAL_W'(whole_reg * 30'd10) + VAL_W'(digit);
                        whole_cnt_next = whole_cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        too_long_next = 1'b1;
                    end
                end
                else if (ph == PH_FRAC)
                begin
                    if (place_reg < CNT_W'(FRACTION_DIGITS))
                    begin
                        frac_next  = VAL_W'(frac_reg * 30'd10) + VAL_W'(digit);
                        place_next = place_reg + CNT_W'(1);
                    end
                    else
                    begin
                        phase_next = PH_BAD;
                    end
                end
                else
                begin
                    // digit after trailing whitespace
                    phase_next = PH_BAD;
                end
            end
            else
            begin
                phase_next = PH_BAD;
            end

            if (text.last)
            begin
                q_push = 1'b1;
                priority if (phase_next == PH_BAD)
                    q_job.status = ST_BAD;
                else if (phase_next == PH_LEAD)
                    q_job.status = ST_BLANK;
                else if (too_long_next)
                    q_job.status = ST_LONG;
                else
                    q_job.status = ST_OK;
                q_job.whole      = whole_next;
                q_job.frac       = frac_next;
                q_job.frac_place = place_next;

                phase_next     = PH_LEAD;
                whole_next     = '0;
                whole_cnt_next = '0;
                too_long_next  = 1'b0;
                frac_next      = '0;
                place_next     = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LEAD;
            whole_reg     <= '0;
            whole_cnt_reg <= '0;
            too_long_reg  <= 1'b0;
            frac_reg      <= '0;
            place_reg     <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            whole_reg     <= whole_next;
            whole_cnt_reg <= whole_cnt_next;
            too_long_reg  <= too_long_next;
            frac_reg      <= frac_next;
            place_reg     <= place_next;
        end
    end

endmodule

// File: design/dap_queue.sv
// Short job queue between front and back, flip-flop storage, one read port.
// Depends on dap_pkg.
module dap_queue #(
    parameter int DEPTH = dap_pkg::DEF_QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  dap_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output dap_pkg::job_t head_job
);
    import dap_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);

    job_t              store_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full       = (count_reg == CNT_QW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = store_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        count_next = count_reg + CNT_QW'(do_push) - CNT_QW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            store_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// File: design/dap_back.sv
// Back end: scales whole and fraction parts (multiply stage), adds and checks against
// max_amount, and holds the result in an output register. Depends on dap_pkg, dap_result_if.
module dap_back #(
    parameter int FRACTION_DIGITS = dap_pkg::DEF_FRACTION_DIGITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         job_valid,
    input  dap_pkg::job_t                job,
    output logic                         job_pop,
    input  logic [dap_pkg::AMOUNT_W-1:0] max_amount,
    dap_result_if.source                 result
);
    import dap_pkg::*;

    logic                s1_valid_reg, s1_valid_next;
    status_t             s1_status_reg;
    logic [AMOUNT_W-1:0] s1_whole_reg, s1_frac_reg;

    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg, out_status_next;
    logic [AMOUNT_W-1:0] out_amount_reg, out_amount_next;

    logic                s2_take, s1_adv;
    logic [CNT_W-1:0]    frac_shift;
    logic [AMOUNT_W-1:0] sum;

    assign s2_take    = !out_valid_reg || result.ready;
    assign s1_adv     = !s1_valid_reg || s2_take;
    assign job_pop    = job_valid && s1_adv;
    assign frac_shift = CNT_W'(FRACTION_DIGITS) - job.frac_place;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_adv)
            s1_valid_next = job_valid;
    end

    // operands widened first so the products keep all 60 bits
    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            s1_status_reg <= job.status;
            s1_whole_reg  <= AMOUNT_W'(job.whole)
                             * AMOUNT_W'(pow10(CNT_W'(FRACTION_DIGITS)));
            s1_frac_reg   <= AMOUNT_W'(job.frac) * AMOUNT_W'(pow10(frac_shift));
        end
    end

    assign sum = s1_whole_reg + s1_frac_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_amount_next = out_amount_reg;
        if (s2_take)
        begin
            out_valid_next  = s1_valid_reg;
            out_status_next = s1_status_reg;
            out_amount_next = '0;
            if (s1_status_reg == ST_OK)
            begin
                if (sum > max_amount)
                    out_status_next = ST_ABOVE;
                else
                    out_amount_next = sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_amount_reg <= out_amount_next;
    end

    assign result.valid  = out_valid_reg;
    assign result.status = out_status_reg;
    assign result.amount = out_amount_reg;

endmodule

// File: design/decimal_amount_parser.sv
// Decimal amount parser: takes text one byte per cycle while the job queue has room (last
// marks the final byte) and returns one status/amount transfer per text, amount in units
// of 10^-FRACTION_DIGITS. A result passes the queue, multiply stage and output register.
// The back end drains one job per cycle while result is ready, so sustained throughput is
// one byte per cycle. max_amount resets to 999999999999999999 and is written through
// cfg_we/cfg_data; the user must write it only while idle, not enforced by the block.
// Depends on dap_pkg, dap_text_if, dap_result_if, dap_front, dap_queue, dap_back.
module decimal_amount_parser #(
    parameter int WHOLE_DIGITS    = dap_pkg::DEF_WHOLE_DIGITS,
    parameter int FRACTION_DIGITS = dap_pkg::DEF_FRACTION_DIGITS,
    parameter int QUEUE_DEPTH     = dap_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    dap_text_if.sink                     text,
    dap_result_if.source                 result,
    input  logic                         cfg_we,
    input  logic [dap_pkg::AMOUNT_W-1:0] cfg_data
);
    import dap_pkg::*;

    logic [AMOUNT_W-1:0] max_reg, max_next;
    logic                q_full, q_push, q_pop, q_valid;
    job_t                q_in, q_head;

    assign max_next = cfg_we ? cfg_data : max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_reg <= RESET_MAX;
        else
            max_reg <= max_next;
    end

    dap_front #(
        .WHOLE_DIGITS    (WHOLE_DIGITS),
        .FRACTION_DIGITS (FRACTION_DIGITS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text),
        .q_full (q_full),
        .q_push (q_push),
        .q_job  (q_in)
    );

    dap_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_job   (q_head)
    );

    dap_back #(
        .FRACTION_DIGITS (FRACTION_DIGITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (q_valid),
        .job        (q_head),
        .job_pop    (q_pop),
        .max_amount (max_reg),
        .result     (result)
    );

endmodule

// File: verif/decimal_amount_parser_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for decimal_amount_parser: streams text bytes, predicts status/amount
// per text and scores every result transfer. Depends on dap_pkg, dap_text_if, dap_result_if.
module decimal_amount_parser_tb;
    import dap_pkg::*;

    localparam int WHOLE_MAX     = DEF_WHOLE_DIGITS;
    localparam int FRAC_MAX      = DEF_FRACTION_DIGITS;
    localparam logic [63:0] ONE_UNIT = 64'd1_000_000_000;   // billionths per whole unit
    localparam int RANDOM_BYTES  = 220;                      // per phase, five phases
    localparam int SETTLE_CYCLES = 10;
    localparam int STALL_LIMIT   = 2000;
    localparam int REPORT_CAP    = 40;

    localparam logic [CH_W-1:0] CH_NUL      = 8'h00;
    localparam logic [CH_W-1:0] CH_ALL_ONES = 8'hFF;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            last;
    } text_byte_t;

    typedef struct packed {
        status_t             status;
        logic [AMOUNT_W-1:0] amount;
    } parse_result_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic [AMOUNT_W-1:0] cfg_data;

    dap_text_if   text_ch ();
    dap_result_if result_ch ();

    decimal_amount_parser uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .text     (text_ch),
        .result   (result_ch),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    text_byte_t    text_bytes_pending[$];
    parse_result_t expected_amounts[$];
    logic [CH_W-1:0] text_buf[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int bytes_sent     = 0;
    int results_seen   = 0;
    int limits_used    = 0;
    int stall_cycles   = 0;

    // parser state as the block should hold it
    phase_t              parse_phase;
    logic [VAL_W-1:0]    whole_acc;
    logic [CNT_W-1:0]    whole_digits;
    logic                whole_overflow;
    logic [VAL_W-1:0]    frac_acc;
    logic [CNT_W-1:0]    frac_digits;
    logic [AMOUNT_W-1:0] amount_limit;

    function automatic void clear_parse_state();
        parse_phase    = PH_LEAD;
        whole_acc      = '0;
        whole_digits   = '0;
        whole_overflow = 1'b0;
        frac_acc       = '0;
        frac_digits    = '0;
    endfunction

    function automatic void absorb_byte(input logic [CH_W-1:0] c, input logic is_last);
        logic          is_ws;
        logic          is_num;
        logic [63:0]   total;
        logic [63:0]   scale;
        parse_result_t r;
        int            k;
        is_ws  = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
        is_num = (c >= CH_ZERO) && (c <= CH_NINE);
        if (parse_phase != PH_BAD)
        begin
            if (is_ws)
            begin
                if (parse_phase == PH_WHOLE || parse_phase == PH_FRAC)
                    parse_phase = PH_TRAIL;
            end
            else if (c == CH_POINT)
                parse_phase = (parse_phase == PH_LEAD || parse_phase == PH_WHOLE) ? PH_FRAC
                                                                                  : PH_BAD;
            else if (is_num)
            begin
                if (parse_phase == PH_LEAD)
                    parse_phase = PH_WHOLE;
                if (parse_phase == PH_WHOLE)
                begin
                    if (whole_digits < WHOLE_MAX)
                    begin
                        whole_acc    = VAL_W'(whole_acc * 10) + VAL_W'(c - CH_ZERO);
                        whole_digits = whole_digits + CNT_W'(1);
                    end
                    else
                        whole_overflow = 1'b1;
                end
                else if (parse_phase == PH_FRAC)
                begin
                    if (frac_digits < FRAC_MAX)
                    begin
                        frac_acc    = VAL_W'(frac_acc * 10) + VAL_W'(c - CH_ZERO);
                        frac_digits = frac_digits + CNT_W'(1);
                    end
                    else
                        parse_phase = PH_BAD;
                end
                else
                    parse_phase = PH_BAD;
            end
            else
                parse_phase = PH_BAD;
        end
        if (is_last)
        begin
            r.amount = '0;
            if (parse_phase == PH_BAD)
                r.status = ST_BAD;
            else if (parse_phase == PH_LEAD)
                r.status = ST_BLANK;
            else if (whole_overflow)
                r.status = ST_LONG;
            else
            begin
                // short fractions are scaled up to the full nine places
                scale = 64'd1;
                for (k = int'(frac_digits); k < FRAC_MAX; k++)
                    scale = 64'(scale * 10);
                total = 64'(whole_acc) * ONE_UNIT + 64'(frac_acc) * scale;
                if (total > 64'(amount_limit))
                    r.status = ST_ABOVE;
                else
                begin
                    r.status = ST_OK;
                    r.amount = total[AMOUNT_W-1:0];
                end
            end
            expected_amounts.push_back(r);
            clear_parse_state();
        end
    endfunction

    // text building
    function automatic void add_string(input string s);
        int k;
        for (k = 0; k < s.len(); k++)
            text_buf.push_back(s[k]);
    endfunction

    function automatic logic [CH_W-1:0] random_space();
        int k;
        k = $urandom_range(5);
        return (k == 5) ? CH_SPACE : CH_TAB + CH_W'(k);
    endfunction

    function automatic logic [CH_W-1:0] random_digit(input logic nines);
        return nines ? CH_NINE : CH_ZERO + CH_W'($urandom_range(9));
    endfunction

    function automatic int close_text();
        int n;
        int k;
        text_byte_t b;
        n = text_buf.size();
        for (k = 0; k < n; k++)
        begin
            b.ch   = text_buf[k];
            b.last = (k == n - 1);
            text_bytes_pending.push_back(b);
        end
        text_buf.delete();
        return n;
    endfunction

    function automatic int queue_random_text();
        int   pick;
        int   n;
        int   k;
        int   pos;
        int   whole_n;
        int   frac_n;
        logic all_nines;
        logic with_point;
        logic [CH_W-1:0] stray;
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            // noise: any byte value
            n = $urandom_range(6, 1);
            for (k = 0; k < n; k++)
                text_buf.push_back(CH_W'($urandom_range(255)));
        end
        else if (pick < 15)
        begin
            n = $urandom_range(3, 1);
            for (k = 0; k < n; k++)
                text_buf.push_back(random_space());
        end
        else
        begin
            all_nines  = ($urandom_range(3) == 0);
            whole_n    = ($urandom_range(9) == 0) ? $urandom_range(11, 10) : $urandom_range(9);
            with_point = ($urandom_range(1) == 1);
            frac_n     = !with_point ? 0 : ($urandom_range(11) == 0) ? 10 : $urandom_range(9);
            if (whole_n == 0 && !with_point)
                whole_n = 1;
            if ($urandom_range(3) == 0)
            begin
                n = $urandom_range(2, 1);
                for (k = 0; k < n; k++)
                    text_buf.push_back(random_space());
            end
            for (k = 0; k < whole_n; k++)
                text_buf.push_back(random_digit(all_nines));
            if (with_point)
                text_buf.push_back(CH_POINT);
            for (k = 0; k < frac_n; k++)
                text_buf.push_back(random_digit(all_nines));
            if ($urandom_range(3) == 0)
            begin
                n = $urandom_range(2, 1);
                for (k = 0; k < n; k++)
                    text_buf.push_back(random_space());
            end
            // broken variants of an otherwise well-formed number
            if (pick >= 85)
            begin
                case ($urandom_range(3))
                    0:       stray = CH_SPACE;
                    1:       stray = CH_POINT;
                    default: stray = CH_W'($urandom_range(255));
                endcase
                if ($urandom_range(3) == 0)
                begin
                    text_buf.push_back(CH_SPACE);
                    text_buf.push_back(random_digit(1'b0));
                end
                else
                begin
                    pos = $urandom_range(text_buf.size());
                    text_buf.insert(pos, stray);
                end
            end
        end
        return close_text();
    endfunction

    task automatic queue_random_phase(input int target);
        int added;
        added = 0;
        while (added < target)
            added += queue_random_text();
    endtask

    task automatic wait_drain();
        while (text_bytes_pending.size() != 0 || text_ch.valid || expected_amounts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [AMOUNT_W-1:0] value);
        @(posedge clk);
        cfg_we       <= 1'b1;
        cfg_data     <= value;
        amount_limit = value;
        limits_used++;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // byte driver
    always @(posedge clk or negedge rst_n)
    begin : text_driver
        text_byte_t nxt;
        if (!rst_n)
        begin
            text_ch.valid <= 1'b0;
            text_ch.ch    <= '0;
            text_ch.last  <= 1'b0;
        end
        else
        begin
            if (text_ch.valid && text_ch.ready)
            begin
                absorb_byte(text_ch.ch, text_ch.last);
                bytes_sent++;
            end
            if (!text_ch.valid || text_ch.ready)
            begin
                if (text_bytes_pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = text_bytes_pending.pop_front();
                    text_ch.valid <= 1'b1;
                    text_ch.ch    <= nxt.ch;
                    text_ch.last  <= nxt.last;
                end
                else
                    text_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor and scoreboard
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        parse_result_t want;
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                results_seen++;
                if (expected_amounts.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_CAP)
                        $display("%0t: unexpected result, expected none, got status %0d amount %0d",
                                 $time, result_ch.status, result_ch.amount);
                end
                else
                begin
                    want = expected_amounts.pop_front();
                    if (result_ch.status !== want.status)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_CAP)
                            $display("%0t: status mismatch, expected %0d, got %0d",
                                     $time, want.status, result_ch.status);
                    end
                    if (result_ch.amount !== want.amount)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_CAP)
                            $display("%0t: amount mismatch, expected %0d, got %0d",
                                     $time, want.amount, result_ch.amount);
                    end
                end
            end
            result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog: cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((text_ch.valid && text_ch.ready) || (result_ch.valid && result_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                         $time, STALL_LIMIT, expected_amounts.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_data        = '0;
        amount_limit    = RESET_MAX;
        clear_parse_state();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: bare points, blank, bad bytes, spacing and point errors
        add_string(".");   void'(close_text());
        add_string("5.");  void'(close_text());
        add_string(".5");  void'(close_text());
        add_string("0");   void'(close_text());
        text_buf.push_back(CH_TAB);
        add_string("7");
        text_buf.push_back(CH_CR);
        void'(close_text());
        text_buf.push_back(CH_NUL);      void'(close_text());
        text_buf.push_back(CH_ALL_ONES); void'(close_text());
        add_string(" ");   void'(close_text());
        add_string(" #");  void'(close_text());
        add_string("1 2"); void'(close_text());
        add_string("..");  void'(close_text());
        queue_random_phase(RANDOM_BYTES);
        wait_drain();

        write_limit('0);
        send_idle_pct = 72;
        queue_random_phase(RANDOM_BYTES);
        wait_drain();

        write_limit(AMOUNT_W'(ONE_UNIT));
        send_idle_pct  = 0;
        recv_stall_pct = 72;
        queue_random_phase(RANDOM_BYTES);
        wait_drain();

        write_limit(60'd123_456_789_012);
        send_idle_pct  = 31;
        recv_stall_pct = 31;
        queue_random_phase(RANDOM_BYTES);
        wait_drain();

        write_limit(RESET_MAX);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_random_phase(RANDOM_BYTES);
        wait_drain();

        $display("Covered %0d text bytes and %0d parse results across %0d amount limits",
                 bytes_sent, results_seen, limits_used + 1);
        $display("with free-running, sender-gapped, receiver-stalled and mixed pacing.");
        if (mismatch_count == 0 && expected_amounts.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
        begin
            $display("%0d mismatches, %0d results never arrived",
                     mismatch_count, expected_amounts.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
